[hw/rtl/tcpq_pkg.sv]
// Package for the two-class priority queue: entry type, action and status codes.
// No dependencies.
package tcpq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam logic [6:0] SENIOR_AGE_RESET = 7'd60;

   localparam logic [2:0] ACT_ENQUEUE  = 3'd0;
   localparam logic [2:0] ACT_DEQUEUE  = 3'd1;
   localparam logic [2:0] ACT_EMERG    = 3'd2;
   localparam logic [2:0] ACT_REMOVE   = 3'd3;
   localparam logic [2:0] ACT_RENUMBER = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   typedef struct packed {
      logic [15:0] ticket;
      logic [6:0]  age;
      logic        hw;
      logic        prio;
      logic        emerg;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request, reset index
      logic step;       // advance index
      logic shift_up;   // store[idx] <= store[idx-1]
      logic shift_down; // store[idx] <= store[idx+1]
      logic put_new;    // store[idx] <= new entry
      logic put_hold;   // store[idx] <= held entry (flags set)
      logic grab;       // hold store[idx]
      logic renum;      // store[idx].ticket <= idx+1
      logic inc;
      logic dec;
      logic idx_to_cnt; // index <= count
      logic dec_idx;    // index <= index-1
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic idx_at_end;   // idx >= count
      logic idx_zero;
      logic idx_last;     // idx+1 >= count
      logic match;        // store[idx].ticket == request ticket
      logic cur_prio;
      logic new_prio;
      logic full;
      logic prev_prio;    // store[idx-1].prio
   } sts_type;

endpackage

[hw/rtl/tcpq_datapath.sv]
// Datapath of the two-class priority queue: entry register file, index, count.
// Depends on tcpq_pkg.
module tcpq_datapath #(
   parameter int QUEUE_DEPTH = tcpq_pkg::DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  tcpq_pkg::cmd_type   cmd,
   output tcpq_pkg::sts_type   sts,
   input  logic [15:0]         req_ticket_number,
   input  logic [6:0]          req_age,
   input  logic                req_is_health_worker,
   input  logic [6:0]          senior_age,
   output tcpq_pkg::entry_type hold,
   output logic [4:0]          count_out
);
   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   tcpq_pkg::entry_type store_ff [QUEUE_DEPTH];
   tcpq_pkg::entry_type hold_ff;
   tcpq_pkg::entry_type new_ff;
   logic [CW-1:0] idx_ff, cnt_ff;
   logic [15:0]   tkt_ff;
   tcpq_pkg::entry_type cur, prev, nxt, held_mod;
   logic [IW-1:0] ia, ip, in1;

   assign ia  = idx_ff[IW-1:0];
   assign ip  = IW'(idx_ff - CW'(1));
   assign in1 = IW'(idx_ff + CW'(1));
   assign cur  = store_ff[ia];
   assign prev = store_ff[ip];
   assign nxt  = store_ff[in1];

   always_comb begin
      held_mod = hold_ff;
      held_mod.prio = 1'b1;
      held_mod.emerg = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tkt_ff <= req_ticket_number;
         new_ff.ticket <= req_ticket_number;
         new_ff.age <= req_age;
         new_ff.hw <= req_is_health_worker;
         new_ff.prio <= (req_age >= senior_age) | req_is_health_worker;
         new_ff.emerg <= 1'b0;
      end
      if (cmd.grab) hold_ff <= cur;
      else if (cmd.put_hold) hold_ff <= held_mod;
      if (cmd.shift_up) store_ff[ia] <= prev;
      else if (cmd.shift_down) store_ff[ia] <= nxt;
      else if (cmd.put_new) store_ff[ia] <= new_ff;
      else if (cmd.put_hold) store_ff[ia] <= held_mod;
      else if (cmd.renum) store_ff[ia].ticket <= 16'(idx_ff + CW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (cmd.load) idx_ff <= '0;
         else if (cmd.idx_to_cnt) idx_ff <= cnt_ff;
         else if (cmd.dec_idx) idx_ff <= idx_ff - CW'(1);
         else if (cmd.step) idx_ff <= idx_ff + CW'(1);
         if (cmd.inc) cnt_ff <= cnt_ff + CW'(1);
         else if (cmd.dec) cnt_ff <= cnt_ff - CW'(1);
      end
   end

   always_comb begin
      sts.idx_at_end = idx_ff >= cnt_ff;
      sts.idx_zero   = idx_ff == '0;
      sts.idx_last   = (idx_ff + CW'(1)) >= cnt_ff;
      sts.match      = cur.ticket == tkt_ff;
      sts.cur_prio   = cur.prio;
      sts.new_prio   = new_ff.prio;
      sts.full       = cnt_ff >= CW'(QUEUE_DEPTH);
      sts.prev_prio  = prev.prio;
   end

   assign hold = hold_ff;
   assign count_out = 5'(cnt_ff);
endmodule

[hw/rtl/tcpq_control.sv]
// Controller of the two-class priority queue: sequences search, shift and result.
// Depends on tcpq_pkg.
module tcpq_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_action,
   output tcpq_pkg::cmd_type cmd,
   input  tcpq_pkg::sts_type sts,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        status,
   output logic              show_entry
);
   typedef enum logic [3:0] {
      S_IDLE, S_ENQ_SCAN, S_ENQ_SHIFT, S_FIND, S_TAKE, S_EMG_SHIFT, S_EMG_PUT,
      S_RENUM, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] act_ff, act_in;
   logic [1:0] st_ff, st_in;
   logic show_ff, show_in;
   logic go;

   assign go = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_DONE;
   assign status = st_ff;
   assign show_entry = show_ff;

   always_comb begin
      state_in = state_ff;
      act_in = act_ff;
      st_in = st_ff;
      show_in = show_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (go) begin
               cmd.load = 1'b1;
               act_in = req_action;
               st_in = tcpq_pkg::ST_OK;
               show_in = 1'b0;
               unique case (req_action)
                  tcpq_pkg::ACT_ENQUEUE:  state_in = S_ENQ_SCAN;
                  tcpq_pkg::ACT_DEQUEUE,
                  tcpq_pkg::ACT_REMOVE,
                  tcpq_pkg::ACT_EMERG:    state_in = S_FIND;
                  tcpq_pkg::ACT_RENUMBER: state_in = S_RENUM;
                  default:                state_in = S_DONE;
               endcase
            end
         end
         S_ENQ_SCAN: begin
            if (sts.full) begin
               st_in = tcpq_pkg::ST_FULL;
               state_in = S_DONE;
            end else if (sts.new_prio && !sts.idx_at_end && sts.cur_prio) begin
               cmd.step = 1'b1;
            end else begin
               // walk index down from count
               cmd.grab = 1'b0;
               cmd.idx_to_cnt = 1'b1;
               state_in = S_ENQ_SHIFT;
            end
         end
         S_ENQ_SHIFT: begin
            // priority: shift up until slot below is priority or head; else tail
            if (sts.idx_zero || !sts.new_prio || sts.prev_prio) begin
               cmd.put_new = 1'b1;
               cmd.inc = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.shift_up = 1'b1;
               cmd.dec_idx = 1'b1;
            end
         end
         S_FIND: begin
            if (sts.idx_at_end) begin
               st_in = tcpq_pkg::ST_NOTFOUND;
               state_in = S_DONE;
            end else if (act_ff == tcpq_pkg::ACT_DEQUEUE || sts.match) begin
               cmd.grab = 1'b1;
               show_in = 1'b1;
               state_in = (act_ff == tcpq_pkg::ACT_EMERG) ? S_EMG_SHIFT : S_TAKE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_TAKE: begin
            if (sts.idx_last) begin
               cmd.dec = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.shift_down = 1'b1;
               cmd.step = 1'b1;
            end
         end
         S_EMG_SHIFT: begin
            if (sts.idx_zero) begin
               state_in = S_EMG_PUT;
            end else begin
               cmd.shift_up = 1'b1;
               cmd.dec_idx = 1'b1;
            end
         end
         S_EMG_PUT: begin
            cmd.put_hold = 1'b1;
            state_in = S_DONE;
         end
         S_RENUM: begin
            if (sts.idx_at_end) begin
               state_in = S_DONE;
            end else begin
               cmd.renum = 1'b1;
               cmd.step = 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         act_ff <= '0;
         st_ff <= '0;
         show_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         act_ff <= act_in;
         st_ff <= st_in;
         show_ff <= show_in;
      end
   end
endmodule

[hw/rtl/two_class_priority_queue.sv]
// Two-class strict-priority ticket queue.
// Channels: req_ (action, ticket_number, age, is_health_worker) in, rsp_ out,
// both valid/stall; one result beat for every request beat; the APB port
// holds senior_age at address 0 (reset 60).
// One request at a time: req_stall is high from acceptance until the result
// beat is taken. A sequencer walks the entry file one slot per cycle to find
// a ticket or the end of the priority run, then shifts entries one slot per
// cycle. The next request is taken in the cycle after the result beat.
// Enqueue: priority entries (age >= senior_age or health worker) go after the
// priority run, others to the tail. Dequeue, emergency (move to front) and
// remove return the entry; renumber sets tickets 1..n.
// Reset empties the queue. While rsp_stall is high the result holds and no
// new request is taken.
// Depends on tcpq_pkg, tcpq_control, tcpq_datapath.
module two_class_priority_queue #(
   parameter int QUEUE_DEPTH = tcpq_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [15:0] req_ticket_number,
   input  logic [6:0]  req_age,
   input  logic        req_is_health_worker,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_out_ticket,
   output logic [6:0]  rsp_out_age,
   output logic        rsp_out_health_worker,
   output logic        rsp_out_priority,
   output logic        rsp_out_emergency,
   output logic [4:0]  rsp_occupancy,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   tcpq_pkg::cmd_type   cmd;
   tcpq_pkg::sts_type   sts;
   tcpq_pkg::entry_type hold;
   logic [6:0] senior_ff;
   logic show;

   assign pready = 1'b1;
   assign prdata = (paddr == 2'd0) ? {25'd0, senior_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) senior_ff <= tcpq_pkg::SENIOR_AGE_RESET;
      else if (psel && penable && pwrite && paddr == 2'd0) senior_ff <= pwdata[6:0];
   end

   tcpq_control u_ctl (
      .clock, .reset, .req_valid, .req_stall, .req_action, .cmd, .sts,
      .rsp_valid, .rsp_stall, .status(rsp_status), .show_entry(show)
   );

   tcpq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
      .clock, .reset, .cmd, .sts, .req_ticket_number, .req_age,
      .req_is_health_worker, .senior_age(senior_ff), .hold, .count_out(rsp_occupancy)
   );

   assign rsp_out_ticket        = show ? hold.ticket : 16'd0;
   assign rsp_out_age           = show ? hold.age : 7'd0;
   assign rsp_out_health_worker = show & hold.hw;
   assign rsp_out_priority      = show & hold.prio;
   assign rsp_out_emergency     = show & hold.emerg;
endmodule
